// File: sv/hsv_to_rgb_pixel_unit_defines.svh
// Assertion macros shared by the HSV to RGB pixel unit.
`ifndef HSV_TO_RGB_PIXEL_UNIT_DEFINES_SVH
`define HSV_TO_RGB_PIXEL_UNIT_DEFINES_SVH

// Check an expression on every clock edge out of reset.
`define H2R_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define H2R_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define H2R_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/h2r_pkg.sv
// Types, constants and widths shared by the HSV to RGB pixel unit.
`default_nettype none

package h2r_pkg;

  // Field widths
  localparam int HUE_W = 13;
  localparam int CH_W  = 8;
  localparam int P_W   = 2 * CH_W;

  // Hue fixed point: fraction bits of a degree
  localparam int HUE_FRAC_BITS = 4;
  localparam int SECTOR_UNITS  = 60 << HUE_FRAC_BITS;
  localparam int FULL_TURN     = 6 * SECTOR_UNITS;
  localparam int NUM_SECTORS   = 6;
  localparam int SEC_W         = 3;

  // Weight, mix term and numerator widths
  localparam int W_W = $clog2(SECTOR_UNITS + 1);
  localparam int T_W = $clog2(255 * SECTOR_UNITS + 1);
  localparam int N_W = T_W + CH_W;

  // Division of the numerator by 255 * sector width via a reciprocal
  localparam int DIVISOR     = 255 * SECTOR_UNITS;
  localparam int RECIP_SHIFT = N_W;
  localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / DIVISOR;
  localparam int R_W  = $clog2(RECIP + 1);
  localparam int PR_W = N_W + R_W;

  localparam logic [CH_W-1:0] CH_MAX = '1;

  // Hue sectors, in order around the wheel
  typedef enum logic [SEC_W-1:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_e;

  // Request payload
  typedef struct packed {
    logic [HUE_W-1:0] hue_sixteenths;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  brightness;
    logic [CH_W-1:0]  alpha_in;
  } pixel_in_t;

  // Result payload
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha_out;
  } pixel_out_t;

  // Control that travels with each request down the pipeline
  typedef struct packed {
    logic            valid;
    logic            black;
    sector_e         sector;
    logic [CH_W-1:0] brightness;
    logic [CH_W-1:0] alpha;
  } stage_ctl_t;

endpackage

`default_nettype wire

// File: sv/h2r_sector.sv
// Stage 1: find the hue sector and the triangular weight inside it.
`default_nettype none

module h2r_sector (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire h2r_pkg::pixel_in_t pix_i,
  output h2r_pkg::stage_ctl_t     ctl_o,
  output logic [h2r_pkg::W_W-1:0] weight_o,
  output logic [h2r_pkg::CH_W-1:0] sat_o
);
  import h2r_pkg::*;

  logic [SEC_W-1:0] sector_idx;
  logic [W_W-1:0]   pos;
  logic [W_W-1:0]   weight_d;
  logic             black;
  stage_ctl_t       ctl_d, ctl_q;
  logic [W_W-1:0]   weight_q;
  logic [CH_W-1:0]  sat_q;

  // Compare against each sector boundary
  always_comb begin
    sector_idx = '0;
    for (int i = 1; i < NUM_SECTORS; i++) begin
      if (32'(pix_i.hue_sixteenths) >= 32'(i * SECTOR_UNITS)) begin
        sector_idx = SEC_W'(i);
      end
    end
  end

  // Position inside the sector; odd sectors run downhill
  always_comb begin
    black    = 32'(pix_i.hue_sixteenths) >= 32'(FULL_TURN);
    pos      = W_W'(32'(pix_i.hue_sixteenths) - 32'(int'(sector_idx) * SECTOR_UNITS));
    weight_d = sector_idx[0] ? W_W'(W_W'(SECTOR_UNITS) - pos) : pos;
  end

  always_comb begin
    ctl_d.valid      = valid_i;
    ctl_d.black      = black;
    ctl_d.sector     = sector_e'(sector_idx);
    ctl_d.brightness = pix_i.brightness;
    ctl_d.alpha      = pix_i.alpha_in;
  end

  // Advance control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    weight_q <= weight_d;
    sat_q    <= pix_i.saturation;
  end

  assign ctl_o    = ctl_q;
  assign weight_o = weight_q;
  assign sat_o    = sat_q;

endmodule

`default_nettype wire

// File: sv/h2r_mix.sv
// Stages 2 and 3: build the X numerator and the zero-channel level.
`default_nettype none

module h2r_mix (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire h2r_pkg::stage_ctl_t ctl_i,
  input  wire logic [h2r_pkg::W_W-1:0]  weight_i,
  input  wire logic [h2r_pkg::CH_W-1:0] sat_i,
  output h2r_pkg::stage_ctl_t      ctl_o,
  output logic [h2r_pkg::N_W-1:0]  num_o,
  output logic [h2r_pkg::CH_W-1:0] zero_o
);
  import h2r_pkg::*;

  logic [CH_W-1:0] inv_sat;
  logic [T_W-1:0]  mix_d, mix_q;
  logic [P_W-1:0]  base_d, base_q;
  stage_ctl_t      ctl2_q, ctl3_q;
  logic [N_W-1:0]  num_d, num_q;
  logic [P_W-1:0]  div_sum;
  logic [CH_W-1:0] zero_d, zero_q;

  // Stage 2: s*w + (255-s)*S and v*(255-s)
  always_comb begin
    inv_sat = CH_MAX - sat_i;
    mix_d   = T_W'(sat_i) * T_W'(weight_i) + T_W'(inv_sat) * T_W'(SECTOR_UNITS);
    base_d  = P_W'(ctl_i.brightness) * P_W'(inv_sat);
  end

  // Stage 3: scale by v; divide the base by 255 with a shift-add
  always_comb begin
    num_d   = N_W'(ctl2_q.brightness) * N_W'(mix_q);
    div_sum = base_q + (base_q >> CH_W) + P_W'(1);
    zero_d  = div_sum[P_W-1:CH_W];
  end

  // Advance control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else begin
      ctl2_q <= ctl_i;
      ctl3_q <= ctl2_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    mix_q  <= mix_d;
    base_q <= base_d;
    num_q  <= num_d;
    zero_q <= zero_d;
  end

  assign ctl_o  = ctl3_q;
  assign num_o  = num_q;
  assign zero_o = zero_q;

endmodule

`default_nettype wire

// File: sv/h2r_quot.sv
// Stages 4 and 5: divide the X numerator by 255 times the sector width.
`default_nettype none

module h2r_quot (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire h2r_pkg::stage_ctl_t      ctl_i,
  input  wire logic [h2r_pkg::N_W-1:0]  num_i,
  input  wire logic [h2r_pkg::CH_W-1:0] zero_i,
  output h2r_pkg::stage_ctl_t           ctl_o,
  output logic [h2r_pkg::CH_W-1:0]      cross_o,
  output logic [h2r_pkg::CH_W-1:0]      zero_o
);
  import h2r_pkg::*;
  `include "hsv_to_rgb_pixel_unit_defines.svh"

  logic [PR_W-1:0] prod;
  logic [CH_W-1:0] est_q;
  logic [N_W-1:0]  num_q;
  logic [CH_W-1:0] zero4_q, zero5_q;
  stage_ctl_t      ctl4_q, ctl5_q;
  logic [N_W-1:0]  rem;
  logic [CH_W-1:0] cross_d, cross_q;

  // Stage 4: reciprocal estimate, at most one short
  assign prod = PR_W'(num_i) * PR_W'(RECIP);

  // Stage 5: correct the estimate with one compare
  always_comb begin
    rem     = num_q - N_W'(est_q) * N_W'(DIVISOR);
    cross_d = (rem >= N_W'(DIVISOR)) ? CH_W'(est_q + CH_W'(1)) : est_q;
  end

  // Advance control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
      ctl5_q <= '0;
    end else begin
      ctl4_q <= ctl_i;
      ctl5_q <= ctl4_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    est_q   <= prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
    num_q   <= num_i;
    zero4_q <= zero_i;
    zero5_q <= zero4_q;
    cross_q <= cross_d;
  end

  assign ctl_o   = ctl5_q;
  assign cross_o = cross_q;
  assign zero_o  = zero5_q;

  `H2R_ASSERT_SAME(a_est_close, ctl4_q.valid && !ctl4_q.black,
    rem < N_W'(2 * DIVISOR), "reciprocal estimate more than one short")
  `H2R_ASSERT_SAME(a_zero_bounded, ctl5_q.valid,
    zero5_q <= ctl5_q.brightness, "zero level above the value level")
  `H2R_ASSERT_SAME(a_cross_bounded, ctl5_q.valid && !ctl5_q.black,
    cross_q >= zero5_q && cross_q <= ctl5_q.brightness,
    "cross channel outside zero..value range")

endmodule

`default_nettype wire

// File: sv/hsv_to_rgb_pixel_unit.sv
// Top level: HSV to RGB pixel converter, six register stages.
// done_o is registered in the final stage, behind the sector, mix and quotient stages.
// Throughput: one request per cycle, every cycle; busy stays low.
// The depth is set by the multiply and reciprocal-divide chain (stages 2 to 5).
// Reset clears every stage valid bit; payload registers are not reset.
// Results cannot be stalled: each is shown for exactly one cycle.
`default_nettype none

module hsv_to_rgb_pixel_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire h2r_pkg::pixel_in_t req_i,
  output logic                    done_o,
  output h2r_pkg::pixel_out_t     rsp_o
);
  import h2r_pkg::*;
  `include "hsv_to_rgb_pixel_unit_defines.svh"

  logic            accept;
  stage_ctl_t      s1_ctl, s3_ctl, s5_ctl;
  logic [W_W-1:0]  s1_weight;
  logic [CH_W-1:0] s1_sat;
  logic [N_W-1:0]  s3_num;
  logic [CH_W-1:0] s3_zero, s5_zero, s5_cross;
  pixel_out_t      rsp_d, rsp_q;
  logic            done_q;

  // Take a request every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  h2r_sector u_sector (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .pix_i    (req_i),
    .ctl_o    (s1_ctl),
    .weight_o (s1_weight),
    .sat_o    (s1_sat)
  );

  h2r_mix u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (s1_ctl),
    .weight_i (s1_weight),
    .sat_i    (s1_sat),
    .ctl_o    (s3_ctl),
    .num_o    (s3_num),
    .zero_o   (s3_zero)
  );

  h2r_quot u_quot (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (s3_ctl),
    .num_i    (s3_num),
    .zero_i   (s3_zero),
    .ctl_o    (s5_ctl),
    .cross_o  (s5_cross),
    .zero_o   (s5_zero)
  );

  // Route chroma, cross and zero levels by sector; drop color past a full turn
  always_comb begin
    rsp_d.alpha_out = s5_ctl.alpha;
    unique case (s5_ctl.sector)
      SEC_R_TO_Y: begin
        rsp_d.red = s5_ctl.brightness; rsp_d.green = s5_cross; rsp_d.blue = s5_zero;
      end
      SEC_Y_TO_G: begin
        rsp_d.red = s5_cross; rsp_d.green = s5_ctl.brightness; rsp_d.blue = s5_zero;
      end
      SEC_G_TO_C: begin
        rsp_d.red = s5_zero; rsp_d.green = s5_ctl.brightness; rsp_d.blue = s5_cross;
      end
      SEC_C_TO_B: begin
        rsp_d.red = s5_zero; rsp_d.green = s5_cross; rsp_d.blue = s5_ctl.brightness;
      end
      SEC_B_TO_M: begin
        rsp_d.red = s5_cross; rsp_d.green = s5_zero; rsp_d.blue = s5_ctl.brightness;
      end
      default: begin
        rsp_d.red = s5_ctl.brightness; rsp_d.green = s5_zero; rsp_d.blue = s5_cross;
      end
    endcase
    if (s5_ctl.black) begin
      rsp_d.red   = '0;
      rsp_d.green = '0;
      rsp_d.blue  = '0;
    end
  end

  // Hold the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s5_ctl.valid;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `H2R_ASSERT_NEXT(a_black_zero, s5_ctl.valid && s5_ctl.black,
    rsp_o.red == '0 && rsp_o.green == '0 && rsp_o.blue == '0,
    "hue past a full turn gave color")
  `H2R_ASSERT_NEXT(a_chroma_kept, s5_ctl.valid && !s5_ctl.black,
    rsp_o.red == $past(s5_ctl.brightness) || rsp_o.green == $past(s5_ctl.brightness)
      || rsp_o.blue == $past(s5_ctl.brightness),
    "no channel carries the value level")
  `H2R_ASSERT_ALWAYS(a_never_busy, !busy, "unit refused a request")

endmodule

`default_nettype wire
